>>> rtl/gbee_pkg.sv
package gbee_pkg;

    // field widths of one request and one result
    localparam int W_MODE   = 2;
    localparam int W_OFFSET = 13;
    localparam int W_COUNT  = 13;
    localparam int W_BYTE   = 8;
    localparam int W_STATUS = 2;
    localparam int W_LEN    = 13;

    // stream widths, payload padded to whole bytes
    localparam int W_S_TDATA = 40;
    localparam int W_S_TUSER = 2;
    localparam int W_M_TDATA = 56;

    typedef enum logic [W_MODE-1:0] {
        MODE_READ   = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    typedef enum logic [W_STATUS-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

>>> rtl/gbee_ram.sv
module gbee_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/gap_buffer_edit_engine.sv
// Gap buffer edit engine: holds up to CAPACITY text bytes in one RAM with a
// movable gap. Requests enter on the slave stream (tuser = mode, tdata =
// offset, count, byte); every request gives exactly one result on the master
// stream (read byte, status, text length, dirty range).
//
// Modes: read a byte, insert a byte, delete a range, clear the dirty range.
// An insert or a delete away from the gap first walks the gap to the offset,
// one byte per cycle through the RAM (read now, write back next cycle).
//
// Path per request: clear, rejected requests and deletes touching the gap go
// from EXEC straight to FIN; a read passes through READ on its way to FIN; an
// insert, or a delete away from the gap, stays in MOVE until the gap reaches
// the offset, then passes through APPLY to FIN.
// Throughput is set by the single RAM port pair: one byte moved per cycle.
// One request is in flight at a time; the result register lets the next
// request be accepted while the previous result still waits on tready.
//
// Reset (synchronous, active low): empty text (gap spans the whole RAM),
// dirty range cleared, no result pending. RAM contents are not cleared;
// every logical byte is written by an insert before it can be read.
// A stalled receiver holds the result in the output register; a finished
// request waits in its final state until that register is free.
module gap_buffer_edit_engine #(
    parameter int CAPACITY = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [gbee_pkg::W_S_TDATA-1:0]  i_s_tdata,  // offset, count, data_byte, pad
    input  logic [gbee_pkg::W_S_TUSER-1:0]  i_s_tuser,  // mode
    // master stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [gbee_pkg::W_M_TDATA-1:0]  o_m_tdata   // read_byte, status, text_length,
                                                        // dirty_valid, dirty_start,
                                                        // dirty_end, pad
);

    import gbee_pkg::*;

    localparam int AW = $clog2(CAPACITY);        // RAM address
    localparam int PW = $clog2(CAPACITY + 1);    // pointers, 0..CAPACITY
    localparam int CW = (PW > 14) ? PW : 14;     // compare width, holds offset + count
    localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MOVE,
        S_APPLY,
        S_READ,
        S_FIN
    } t_state;

    t_state               r_state;
    t_mode                r_mode;
    logic [W_OFFSET-1:0]  r_off;
    logic [W_COUNT-1:0]   r_cnt;
    logic [W_BYTE-1:0]    r_dat;

    logic [PW-1:0]        r_gf;      // first gap slot
    logic [PW-1:0]        r_gl;      // first slot after the gap
    logic                 r_dirty;
    logic [PW-1:0]        r_dlo;
    logic [PW-1:0]        r_dhi;

    t_status              r_status;
    logic [W_BYTE-1:0]    r_rd;

    // pending write of a gap move: data arrives from RAM in the next cycle
    logic                 r_pw_valid;
    logic [AW-1:0]        r_pw_addr;

    // result register
    logic                 r_out_valid;
    logic [W_M_TDATA-1:0] r_out_data;

    // ---------------------------------------------------------------
    // derived values
    // ---------------------------------------------------------------
    logic [PW-1:0] len;
    logic [CW-1:0] len_w, off_w, cnt_w, stop_w, gf_w;
    logic [PW-1:0] off_p, cnt_p;
    logic          mv_left, mv_right;

    assign len    = CAP_P - (r_gl - r_gf);
    assign len_w  = CW'(len);
    assign off_w  = CW'(r_off);
    assign cnt_w  = CW'(r_cnt);
    assign stop_w = off_w + cnt_w;
    assign gf_w   = CW'(r_gf);
    // valid once the range check has passed
    assign off_p  = PW'(r_off);
    assign cnt_p  = PW'(r_cnt);

    assign mv_left  = (r_gf > off_p);
    assign mv_right = (r_gf < off_p) && (r_gl < CAP_P);

    // dirty range update for a successful insert or delete
    logic [PW-1:0] dlo_n, dhi_n;
    logic [CW-1:0] dlo_w, dhi_w;

    assign dlo_w = CW'(r_dlo);
    assign dhi_w = CW'(r_dhi);

    always_comb begin
        dlo_n = r_dlo;
        dhi_n = r_dhi;
        if (r_mode == MODE_INSERT) begin
            if (!r_dirty) begin
                dlo_n = off_p;
                dhi_n = off_p + PW'(1);
            end else begin
                if (off_p < r_dlo) begin
                    dlo_n = off_p;
                end
                if (off_w + CW'(1) > dhi_w) begin
                    dhi_n = off_p + PW'(1);
                end
            end
        end else begin
            if (!r_dirty) begin
                dlo_n = off_p;
                dhi_n = off_p;
            end else begin
                if (dlo_w > off_w) begin
                    dlo_n = (dlo_w > cnt_w) ? PW'(dlo_w - cnt_w) : '0;
                end
                if (dhi_w > stop_w) begin
                    dhi_n = PW'(dhi_w - cnt_w);
                end else if (dhi_w > off_w) begin
                    dhi_n = off_p;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // text RAM
    // ---------------------------------------------------------------
    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [W_BYTE-1:0] ram_wdata, ram_rdata;
    logic [CW-1:0]     rd_idx;

    assign rd_idx = (off_w < gf_w) ? off_w : off_w + CW'(r_gl - r_gf);

    always_comb begin
        ram_raddr = rd_idx[AW-1:0];
        if (r_state == S_MOVE) begin
            if (mv_left) begin
                ram_raddr = AW'(r_gf - PW'(1));
            end else begin
                ram_raddr = r_gl[AW-1:0];
            end
        end
    end

    // a move write and the insert write never fall in the same cycle
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pw_addr;
        ram_wdata = ram_rdata;
        if (r_pw_valid) begin
            ram_we = 1'b1;
        end else if (r_state == S_APPLY && r_mode == MODE_INSERT) begin
            ram_we    = 1'b1;
            ram_waddr = r_gf[AW-1:0];
            ram_wdata = r_dat;
        end
    end

    gbee_ram #(
        .WIDTH (W_BYTE),
        .DEPTH (CAPACITY)
    ) u_text_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // control
    // ---------------------------------------------------------------
    logic [W_LEN-1:0] len_o, dlo_o, dhi_o;

    assign len_o = len_w[W_LEN-1:0];
    assign dlo_o = r_dirty ? dlo_w[W_LEN-1:0] : '0;
    assign dhi_o = r_dirty ? dhi_w[W_LEN-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gf        <= '0;
            r_gl        <= CAP_P;
            r_dirty     <= 1'b0;
            r_dlo       <= '0;
            r_dhi       <= '0;
            r_pw_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pw_valid <= 1'b0;
            if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_mode  <= t_mode'(i_s_tuser[W_MODE-1:0]);
                        r_off   <= i_s_tdata[W_OFFSET-1:0];
                        r_cnt   <= i_s_tdata[W_OFFSET +: W_COUNT];
                        r_dat   <= i_s_tdata[W_OFFSET+W_COUNT +: W_BYTE];
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_status <= ST_OK;
                    r_rd     <= '0;
                    r_state  <= S_FIN;
                    case (r_mode)
                        MODE_READ: begin
                            if (off_w < len_w) begin
                                r_state <= S_READ;   // RAM read issued this cycle
                            end else begin
                                r_status <= ST_RANGE;
                            end
                        end
                        MODE_INSERT: begin
                            if (off_w > len_w) begin
                                r_status <= ST_RANGE;
                            end else if (len == CAP_P) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_state <= S_MOVE;
                            end
                        end
                        MODE_DELETE: begin
                            if (stop_w > len_w) begin
                                r_status <= ST_RANGE;
                            end else if (off_w == gf_w) begin
                                r_gl    <= r_gl + cnt_p;
                                r_dirty <= 1'b1;
                                r_dlo   <= dlo_n;
                                r_dhi   <= dhi_n;
                            end else if (stop_w == gf_w) begin
                                r_gf    <= r_gf - cnt_p;
                                r_dirty <= 1'b1;
                                r_dlo   <= dlo_n;
                                r_dhi   <= dhi_n;
                            end else begin
                                r_state <= S_MOVE;
                            end
                        end
                        MODE_CLEAR: begin
                            r_dirty <= 1'b0;
                            r_dlo   <= '0;
                            r_dhi   <= '0;
                        end
                        default: begin
                            r_status <= ST_OK;
                        end
                    endcase
                end
                S_MOVE: begin
                    // one byte per cycle; its write lands next cycle
                    if (mv_left) begin
                        r_gf       <= r_gf - PW'(1);
                        r_gl       <= r_gl - PW'(1);
                        r_pw_valid <= 1'b1;
                        r_pw_addr  <= AW'(r_gl - PW'(1));
                    end else if (mv_right) begin
                        r_gf       <= r_gf + PW'(1);
                        r_gl       <= r_gl + PW'(1);
                        r_pw_valid <= 1'b1;
                        r_pw_addr  <= r_gf[AW-1:0];
                    end else begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    if (r_mode == MODE_INSERT) begin
                        r_gf <= r_gf + PW'(1);
                    end else begin
                        r_gl <= r_gl + cnt_p;
                    end
                    r_dirty <= 1'b1;
                    r_dlo   <= dlo_n;
                    r_dhi   <= dhi_n;
                    r_state <= S_FIN;
                end
                S_READ: begin
                    r_rd    <= ram_rdata;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {
                            {(W_M_TDATA - 2*W_LEN - W_LEN - 1 - W_STATUS - W_BYTE){1'b0}},
                            dhi_o, dlo_o, r_dirty, len_o, r_status, r_rd
                        };
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

>>> test/gap_buffer_edit_engine_tb.sv
module gap_buffer_edit_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gbee_pkg::*;

    localparam int CAP        = 4096;
    localparam int HALF_CLK   = 6;
    localparam int RST_CYCLES = 11;
    localparam int N_RANDOM   = 1460;
    // text length reached by the plain appends before the random part
    localparam int FILL_LEN   = 300;
    // soft ceiling on text length during the random part, keeps gap walks short
    localparam int LEN_CEIL   = 400;
    // one long receiver stall, counted in results, to back the block up
    localparam int HOLD_AT    = 600;
    localparam int HOLD_CYC   = 300;
    localparam int DRAIN_CYC  = 40;

    // one result as it travels on o_m_tdata, unpacked
    typedef struct packed {
        logic [W_BYTE-1:0]   rd;
        logic [W_STATUS-1:0] st;
        logic [W_LEN-1:0]    len;
        logic                dv;
        logic [W_LEN-1:0]    ds;
        logic [W_LEN-1:0]    de;
    } t_edit_result;

    // one directed row; typed == 1 means res is written out by hand
    typedef struct {
        t_mode               mode;
        logic [W_OFFSET-1:0] off;
        logic [W_COUNT-1:0]  cnt;
        logic [W_BYTE-1:0]   dat;
        bit                  typed;
        t_edit_result        res;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [W_S_TDATA-1:0] i_s_tdata;
    logic [W_S_TUSER-1:0] i_s_tuser;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [W_M_TDATA-1:0] o_m_tdata;

    gap_buffer_edit_engine #(
        .CAPACITY (CAP)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial i_clk = 1'b0;
    always #HALF_CLK i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Shadow copy of the text buffer. Updated at the edge a request is
    // accepted, so the queue of pending results stays in request order.
    // ---------------------------------------------------------------------
    logic [7:0]   text_mem [CAP];
    int           gap_lo;
    int           gap_hi;
    bit           dflag;
    int           dlo;
    int           dhi;

    t_edit_result pending_results[$];
    t_row         directed_rows[$];
    int           n_errors;
    int           sent_count;
    int           got_count;

    function automatic int text_length();
        return CAP - (gap_hi - gap_lo);
    endfunction

    // walk the gap to pos one byte at a time, like the RAM does
    function automatic void shift_gap(input int pos);
        while (gap_lo > pos) begin
            gap_lo--;
            gap_hi--;
            text_mem[gap_hi] = text_mem[gap_lo];
        end
        while (gap_lo < pos && gap_hi < CAP) begin
            text_mem[gap_lo] = text_mem[gap_hi];
            gap_lo++;
            gap_hi++;
        end
    endfunction

    function automatic t_edit_result apply_edit(input t_mode m, input int off, input int cnt,
                                                input logic [7:0] dat);
        t_edit_result r;
        int           len;
        int           stop;
        r    = '0;
        len  = text_length();
        stop = off + cnt;
        case (m)
            MODE_READ: begin
                if (off < len) begin
                    r.rd = (off < gap_lo) ? text_mem[off] : text_mem[off + gap_hi - gap_lo];
                end else begin
                    r.st = ST_RANGE;
                end
            end
            MODE_INSERT: begin
                if (off > len) begin
                    r.st = ST_RANGE;          // range check wins over full
                end else if (len >= CAP) begin
                    r.st = ST_FULL;
                end else begin
                    shift_gap(off);
                    text_mem[gap_lo] = dat;
                    gap_lo++;
                    if (!dflag) begin
                        dflag = 1'b1;
                        dlo   = off;
                        dhi   = off + 1;
                    end else begin
                        if (off < dlo) dlo = off;
                        if (off + 1 > dhi) dhi = off + 1;
                    end
                end
            end
            MODE_DELETE: begin
                if (stop > len) begin
                    r.st = ST_RANGE;
                end else begin
                    // deletes touching the gap need no walk
                    if (off == gap_lo) begin
                        gap_hi += cnt;
                    end else if (stop == gap_lo) begin
                        gap_lo -= cnt;
                    end else begin
                        shift_gap(off);
                        gap_hi += cnt;
                    end
                    if (!dflag) begin
                        dflag = 1'b1;
                        dlo   = off;
                        dhi   = off;
                    end else begin
                        if (dlo > off) dlo = (dlo > cnt) ? dlo - cnt : 0;
                        if (dhi > stop) begin
                            dhi -= cnt;
                        end else if (dhi > off) begin
                            dhi = off;
                        end
                    end
                end
            end
            default: begin
                dflag = 1'b0;
                dlo   = 0;
                dhi   = 0;
            end
        endcase
        r.len = W_LEN'(text_length());
        r.dv  = dflag;
        r.ds  = dflag ? W_LEN'(dlo) : '0;
        r.de  = dflag ? W_LEN'(dhi) : '0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: mismatch on result %0d: %s got %0d want %0d",
                 $realtime, got_count, what, got, want);
        n_errors++;
    endtask

    task automatic add_row(input t_mode m, input int off, input int cnt, input int dat,
                           input bit typed, input int st, input int len,
                           input int dv, input int ds, input int de);
        t_row row;
        row.mode   = m;
        row.off    = W_OFFSET'(off);
        row.cnt    = W_COUNT'(cnt);
        row.dat    = W_BYTE'(dat);
        row.typed  = typed;
        row.res    = '0;
        row.res.st = W_STATUS'(st);
        row.res.len = W_LEN'(len);
        row.res.dv = dv[0];
        row.res.ds = W_LEN'(ds);
        row.res.de = W_LEN'(de);
        directed_rows.push_back(row);
    endtask

    // idle pattern: back to back for the first 15 of every 100 items, else a random idle gap
    function automatic int draw_idle(input int n);
        return ((n % 100) < 15) ? 0 : $urandom_range(0, 14);
    endfunction

    // Offer one request, wait for the handshake, then record what it should
    // produce. A hand-typed result replaces the shadow one, but the shadow
    // state still advances.
    task automatic send_request(input t_mode m, input logic [W_OFFSET-1:0] off,
                                input logic [W_COUNT-1:0] cnt, input logic [W_BYTE-1:0] dat,
                                input bit typed, input t_edit_result typed_res);
        int           idle;
        t_edit_result r;
        idle = draw_idle(sent_count);
        if (idle > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= m;
        i_s_tdata  <= {6'b0, dat, cnt, off};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        r = apply_edit(m, int'(off), int'(cnt), dat);
        pending_results.push_back(typed ? typed_res : r);
        sent_count++;
    endtask

    // plain request checked against the shadow model
    task automatic send_plain(input t_mode m, input int off, input int cnt, input int dat);
        send_request(m, W_OFFSET'(off), W_COUNT'(cnt), W_BYTE'(dat), 1'b0, '0);
    endtask

    // Random request. Mostly well-formed edits near the live text with the
    // odd out-of-range or all-bits value mixed in.
    task automatic send_random();
        int    len;
        int    r;
        int    off;
        int    cnt;
        int    room;
        t_mode m;
        len = text_length();
        r   = $urandom_range(0, 99);
        if (len >= LEN_CEIL) begin
            m = (r < 60) ? MODE_DELETE : MODE_READ;
        end else if (r < 38) begin
            m = MODE_INSERT;
        end else if (r < 58) begin
            m = MODE_DELETE;
        end else if (r < 92) begin
            m = MODE_READ;
        end else begin
            m = MODE_CLEAR;
        end
        off = (m == MODE_READ && len > 0) ? $urandom_range(0, len - 1) : $urandom_range(0, len);
        cnt = $urandom_range(0, (1 << W_COUNT) - 1);
        if (m == MODE_DELETE) begin
            room = (len >= LEN_CEIL) ? 64 : 8;
            case ($urandom_range(0, 3))
                0: off = gap_lo;                           // start right at the gap
                1: begin                                   // end right at the gap
                    cnt = $urandom_range(0, (gap_lo < room) ? gap_lo : room);
                    off = gap_lo - cnt;
                end
                default: ;
            endcase
            if ($urandom_range(0, 15) != 0) begin
                if ($urandom_range(0, 3) != 1) begin
                    cnt = $urandom_range(0, ((len - off) < room) ? (len - off) : room);
                end
            end
        end
        if ($urandom_range(0, 19) == 0) off = $urandom_range(0, (1 << W_OFFSET) - 1);
        send_plain(m, off, cnt, $urandom_range(0, 255));
    endtask

    // ---------------------------------------------------------------------
    // Receiver: random back-pressure, one long hold-off, field-by-field
    // compare against the oldest pending result.
    // ---------------------------------------------------------------------
    initial begin : result_sink
        int           idle;
        t_edit_result want;
        t_edit_result got;
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            idle = (got_count == HOLD_AT) ? HOLD_CYC : draw_idle(got_count);
            if (idle > 0) begin
                i_m_tready <= 1'b0;
                repeat (idle) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
            got.rd  = o_m_tdata[7:0];
            got.st  = o_m_tdata[9:8];
            got.len = o_m_tdata[22:10];
            got.dv  = o_m_tdata[23];
            got.ds  = o_m_tdata[36:24];
            got.de  = o_m_tdata[49:37];
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, tdata", o_m_tdata, 0);
            end else begin
                want = pending_results.pop_front();
                if (got.rd  !== want.rd)  report_mismatch("read_byte", got.rd, want.rd);
                if (got.st  !== want.st)  report_mismatch("status", got.st, want.st);
                if (got.len !== want.len) report_mismatch("text_length", got.len, want.len);
                if (got.dv  !== want.dv)  report_mismatch("dirty_valid", got.dv, want.dv);
                if (got.ds  !== want.ds)  report_mismatch("dirty_start", got.ds, want.ds);
                if (got.de  !== want.de)  report_mismatch("dirty_end", got.de, want.de);
            end
            got_count++;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus: directed table, a few hundred appends, then random edits.
    // ---------------------------------------------------------------------
    initial begin : request_source
        t_row row;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;
        n_errors   = 0;
        sent_count = 0;
        got_count  = 0;
        foreach (text_mem[i]) text_mem[i] = 8'h00;
        gap_lo = 0;
        gap_hi = CAP;
        dflag  = 1'b0;
        dlo    = 0;
        dhi    = 0;

        // empty buffer: out of range except a zero-length delete, clear and insert at 0
        add_row(MODE_READ,   0,    0,    8'h00, 1, ST_RANGE, 0, 0, 0, 0);
        add_row(MODE_READ,   8191, 8191, 8'hFF, 1, ST_RANGE, 0, 0, 0, 0);
        add_row(MODE_INSERT, 1,    0,    8'hAA, 1, ST_RANGE, 0, 0, 0, 0);
        add_row(MODE_INSERT, 8191, 8191, 8'hFF, 1, ST_RANGE, 0, 0, 0, 0);
        add_row(MODE_DELETE, 0,    1,    8'h00, 1, ST_RANGE, 0, 0, 0, 0);
        add_row(MODE_DELETE, 8191, 8191, 8'hFF, 1, ST_RANGE, 0, 0, 0, 0);
        add_row(MODE_DELETE, 0,    0,    8'h00, 1, ST_OK,    0, 1, 0, 0);
        add_row(MODE_CLEAR,  8191, 8191, 8'hFF, 1, ST_OK,    0, 0, 0, 0);
        add_row(MODE_INSERT, 0,    8191, 8'hFF, 1, ST_OK,    1, 1, 0, 1);
        // small text, gap walked both ways
        add_row(MODE_INSERT, 0,    0,    8'h00, 0, 0, 0, 0, 0, 0);
        add_row(MODE_INSERT, 2,    0,    8'h5A, 0, 0, 0, 0, 0, 0);
        add_row(MODE_INSERT, 1,    0,    8'hA5, 0, 0, 0, 0, 0, 0);
        add_row(MODE_READ,   0,    0,    8'h00, 0, 0, 0, 0, 0, 0);
        add_row(MODE_READ,   3,    0,    8'h00, 0, 0, 0, 0, 0, 0);
        add_row(MODE_READ,   4,    0,    8'h00, 0, 0, 0, 0, 0, 0);
        add_row(MODE_DELETE, 1,    1,    8'h00, 0, 0, 0, 0, 0, 0);  // ends at the gap
        add_row(MODE_DELETE, 1,    1,    8'h00, 0, 0, 0, 0, 0, 0);  // starts at the gap
        add_row(MODE_DELETE, 0,    0,    8'h00, 0, 0, 0, 0, 0, 0);
        add_row(MODE_INSERT, 0,    0,    8'h3C, 0, 0, 0, 0, 0, 0);
        add_row(MODE_CLEAR,  0,    0,    8'h00, 0, 0, 0, 0, 0, 0);
        add_row(MODE_DELETE, 1,    1,    8'h00, 0, 0, 0, 0, 0, 0);  // first change after clear
        add_row(MODE_DELETE, 0,    1,    8'h00, 0, 0, 0, 0, 0, 0);  // ends at the gap
        add_row(MODE_READ,   0,    0,    8'h00, 0, 0, 0, 0, 0, 0);

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_request(row.mode, row.off, row.cnt, row.dat, row.typed, row.res);
        end

        // appends sit at the gap, so after the first one nothing is walked
        while (text_length() < FILL_LEN) begin
            send_plain(MODE_INSERT, text_length(), $urandom_range(0, 8191),
                       $urandom_range(0, 255));
        end
        send_plain(MODE_INSERT, FILL_LEN + 1, 0, 8'h44);   // one past the end
        send_plain(MODE_INSERT, 8191, 8191, 8'hFF);        // all-ones offset
        send_plain(MODE_READ,   FILL_LEN - 1, 0, 8'h00);
        send_plain(MODE_READ,   FILL_LEN, 0, 8'h00);
        send_plain(MODE_DELETE, FILL_LEN, 0, 8'h00);
        send_plain(MODE_DELETE, 0, FILL_LEN + 1, 8'h00);
        send_plain(MODE_DELETE, 100,  80,   8'h00);   // long walk down
        send_plain(MODE_READ,   99,   0,    8'h00);
        send_plain(MODE_READ,   100,  0,    8'h00);
        send_plain(MODE_DELETE, 0, text_length() - 150, 8'h00);
        send_plain(MODE_CLEAR,  0,    0,    8'h00);

        repeat (N_RANDOM) send_random();

        // back to an empty buffer once more
        send_plain(MODE_DELETE, 0, text_length(), 8'h00);
        send_plain(MODE_READ,   0, 0, 8'h00);

        @(posedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // hard stop well past the slowest legal run
    initial begin : watchdog
        #100_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
